// File: rtl/nrld_pkg.sv
// ----------------------------------------------------------------------------
// nrld_pkg
// Shared types and constants of the nibble run-length row decoder.
// ----------------------------------------------------------------------------
package nrld_pkg;

	localparam int HeaderBytes = 4;
	localparam int MaxResults  = 3;

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_LIT  = 2'd1,
		PH_REP  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SPAN = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] col;
		logic [7:0] row;
		logic [3:0] width;
		logic [3:0] tile;
	} res_t;

	typedef struct packed {
		logic       func;
		logic [7:0] start_col;
		logic [7:0] end_col;
		logic [7:0] row;
		logic [7:0] run_bytes;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		res_t [MaxResults-1:0] res;
		logic [1:0]            count;
	} dec_out_t;

endpackage

// File: rtl/nrld_dec.sv
// ----------------------------------------------------------------------------
// nrld_dec
// Run state registers and the combinational decode of one header or data item.
// ----------------------------------------------------------------------------
module nrld_dec #(
	parameter int HEADER_BYTES = nrld_pkg::HeaderBytes
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               enable,
	input  nrld_pkg::item_t    item,
	output nrld_pkg::dec_out_t dec
);

	localparam logic [7:0] HdrBytes = 8'(HEADER_BYTES);

	logic [8:0]       cur_col_q, cur_col_d;
	logic [7:0]       stop_col_q, stop_col_d;
	logic [7:0]       cur_row_q, cur_row_d;
	logic [7:0]       bytes_left_q, bytes_left_d;
	nrld_pkg::phase_t phase_q, phase_d;
	logic [3:0]       lit_left_q, lit_left_d;
	logic [3:0]       rep_len_q, rep_len_d;
	logic             finished_q, finished_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q    <= '0;
			stop_col_q   <= '0;
			cur_row_q    <= '0;
			bytes_left_q <= '0;
			phase_q      <= nrld_pkg::PH_CTRL;
			lit_left_q   <= '0;
			rep_len_q    <= '0;
			finished_q   <= 1'b0;
		end else if (enable) begin
			cur_col_q    <= cur_col_d;
			stop_col_q   <= stop_col_d;
			cur_row_q    <= cur_row_d;
			bytes_left_q <= bytes_left_d;
			phase_q      <= phase_d;
			lit_left_q   <= lit_left_d;
			rep_len_q    <= rep_len_d;
			finished_q   <= finished_d;
		end
	end

	always_comb begin
		logic [3:0] nib;
		logic [8:0] avail;
		logic       span_done;
		logic       st_fire;
		logic       st_ok;

		cur_col_d    = cur_col_q;
		stop_col_d   = stop_col_q;
		cur_row_d    = cur_row_q;
		bytes_left_d = bytes_left_q;
		phase_d      = phase_q;
		lit_left_d   = lit_left_q;
		rep_len_d    = rep_len_q;
		finished_d   = finished_q;
		dec          = '0;
		nib          = '0;
		avail        = '0;
		span_done    = 1'b0;
		st_fire      = 1'b0;
		st_ok        = 1'b0;

		if (!item.func) begin
			cur_col_d    = {1'b0, item.start_col};
			stop_col_d   = item.end_col;
			cur_row_d    = item.row;
			bytes_left_d = (item.run_bytes > HdrBytes) ? item.run_bytes - HdrBytes : 8'd0;
			phase_d      = nrld_pkg::PH_CTRL;
			lit_left_d   = '0;
			rep_len_d    = '0;
			finished_d   = 1'b0;
			if (item.start_col >= item.end_col || item.run_bytes <= HdrBytes) begin
				st_ok = (item.start_col >= item.end_col) && (item.run_bytes == HdrBytes);
				dec.res[dec.count] = '{kind: st_ok ? nrld_pkg::KIND_OK : nrld_pkg::KIND_ERR,
					col: item.start_col, row: item.row, width: 4'd0, tile: 4'd0};
				dec.count  = dec.count + 2'd1;
				finished_d = 1'b1;
			end
		end else if (!finished_q && bytes_left_q != 8'd0) begin
			bytes_left_d = bytes_left_q - 8'd1;
			for (int k = 0; k < 2; k++) begin
				if (!finished_d) begin
					nib       = (k == 0) ? item.data_byte[7:4] : item.data_byte[3:0];
					avail     = {bytes_left_d, 1'b0} + ((k == 0) ? 9'd1 : 9'd0);
					span_done = 1'b0;
					st_fire   = 1'b0;
					st_ok     = 1'b0;
					unique case (phase_d)
						nrld_pkg::PH_CTRL: begin
							if (!nib[3]) begin
								if ({5'd0, nib} + 9'd1 > avail) begin
									st_fire = 1'b1;
								end else begin
									lit_left_d = nib + 4'd1;
									phase_d    = nrld_pkg::PH_LIT;
								end
							end else begin
								if (avail == 9'd0) begin
									st_fire = 1'b1;
								end else begin
									rep_len_d = nib - 4'd6;
									phase_d   = nrld_pkg::PH_REP;
								end
							end
						end
						nrld_pkg::PH_LIT: begin
							dec.res[dec.count] = '{kind: nrld_pkg::KIND_SPAN,
								col: cur_col_d[7:0], row: cur_row_d, width: 4'd1, tile: nib};
							dec.count  = dec.count + 2'd1;
							cur_col_d  = cur_col_d + 9'd1;
							lit_left_d = lit_left_d - 4'd1;
							if (lit_left_d == 4'd0) begin
								phase_d   = nrld_pkg::PH_CTRL;
								span_done = 1'b1;
							end
						end
						nrld_pkg::PH_REP: begin
							dec.res[dec.count] = '{kind: nrld_pkg::KIND_SPAN,
								col: cur_col_d[7:0], row: cur_row_d, width: rep_len_d, tile: nib};
							dec.count = dec.count + 2'd1;
							cur_col_d = cur_col_d + {5'd0, rep_len_d};
							phase_d   = nrld_pkg::PH_CTRL;
							span_done = 1'b1;
						end
						default: begin
						end
					endcase
					if (span_done && cur_col_d >= {1'b0, stop_col_d}) begin
						st_fire = 1'b1;
						st_ok   = (bytes_left_d == 8'd0);
					end
					if (st_fire) begin
						dec.res[dec.count] = '{kind: st_ok ? nrld_pkg::KIND_OK : nrld_pkg::KIND_ERR,
							col: cur_col_d[7:0], row: cur_row_d, width: 4'd0, tile: 4'd0};
						dec.count  = dec.count + 2'd1;
						finished_d = 1'b1;
					end
				end
			end
			if (!finished_d && bytes_left_d == 8'd0) begin
				dec.res[dec.count] = '{kind: nrld_pkg::KIND_ERR,
					col: cur_col_d[7:0], row: cur_row_d, width: 4'd0, tile: 4'd0};
				dec.count  = dec.count + 2'd1;
				finished_d = 1'b1;
			end
		end
	end

endmodule

// File: rtl/nrld_obuf.sv
// ----------------------------------------------------------------------------
// nrld_obuf
// Result register that holds the results of one item and sends them in order.
// ----------------------------------------------------------------------------
module nrld_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  nrld_pkg::dec_out_t dec,
	input  logic               out_stall,
	output logic               can_load,
	output logic               out_valid,
	output nrld_pkg::res_t     res,
	output logic               last
);

	nrld_pkg::res_t [nrld_pkg::MaxResults-1:0] buf_q;
	logic [1:0] cnt_q;
	logic [1:0] rd_q;
	logic       take;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
	assign res       = buf_q[rd_q];
	assign last      = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= dec.count;
			rd_q  <= '0;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= dec.res;
		end
	end

endmodule

// File: rtl/nibble_run_length_row_decoder.sv
// ----------------------------------------------------------------------------
// nibble_run_length_row_decoder
// Decodes run-length-coded map rows into tile spans and a closing status.
// ----------------------------------------------------------------------------
// An item is registered at the input, decoded combinationally and its
// results, up to three for one data byte, are loaded into the result
// register and sent one per cycle while out_stall is low. The next item is
// taken while results are still pending and is decoded in the cycle the last
// pending result leaves, so the sustained rate without stalls is one item per
// cycle or one result per cycle, whichever is slower. Items that cause no
// result pass at one per cycle.
module nibble_run_length_row_decoder #(
	parameter int HEADER_BYTES = nrld_pkg::HeaderBytes
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] start_col,
	input  logic [7:0] end_col,
	input  logic [7:0] row,
	input  logic [7:0] run_bytes,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] col,
	output logic [7:0] row_out,
	output logic [3:0] width,
	output logic [3:0] tile,
	output logic       last
);

	nrld_pkg::item_t    item_s1;
	logic               valid_s1;
	logic               can_load;
	logic               proc;
	nrld_pkg::dec_out_t dec;
	nrld_pkg::res_t     res;

	assign proc     = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{func: func, start_col: start_col, end_col: end_col,
				row: row, run_bytes: run_bytes, data_byte: data_byte};
		end
	end

	nrld_dec #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.enable (proc),
		.item   (item_s1),
		.dec    (dec)
	);

	nrld_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (proc),
		.dec       (dec),
		.out_stall (out_stall),
		.can_load  (can_load),
		.out_valid (out_valid),
		.res       (res),
		.last      (last)
	);

	assign kind    = res.kind;
	assign col     = res.col;
	assign row_out = res.row;
	assign width   = res.width;
	assign tile    = res.tile;

endmodule

// File: rtl/nrld_check.sv
// ----------------------------------------------------------------------------
// nrld_check
// Port-level checks of the row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module nrld_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] col,
	input logic [7:0] row_out,
	input logic [3:0] width,
	input logic [3:0] tile,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(col)
		&& $stable(row_out) && $stable(width) && $stable(tile) && $stable(last))
		else $error("stalled result changed");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 2'd3)
		else $error("undefined result kind");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != 2'd0 |-> width == 4'd0 && tile == 4'd0 && last)
		else $error("status result malformed or not last");

	a_span_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == 2'd0 |-> width != 4'd0 && width <= 4'd9)
		else $error("span width out of range");

endmodule

bind nibble_run_length_row_decoder nrld_check u_nrld_check (.*);
